// ===== sv/sptir_pkg.sv =====
// ----------------------------------------------------------------------------
// sptir_pkg
// Shared types and constants for the shadow page table index router.
// ----------------------------------------------------------------------------
package sptir_pkg;

	localparam int DEF_MAX_LEVELS = 16;

	localparam int DIM_W       = 11;  // map / window size and origin registers
	localparam int BASE_W      = 32;  // table base entry and page table index
	localparam int RULE_W      = 6;   // level rule register
	localparam int LEVEL_W     = 8;
	localparam int COORD_W     = 12;
	localparam int LOCAL_W     = 10;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAP_WIDTH     = 3'd0,
		REG_MAP_HEIGHT    = 3'd1,
		REG_WIN_WIDTH     = 3'd2,
		REG_WIN_HEIGHT    = 3'd3,
		REG_WIN_ORIGIN_X  = 3'd4,
		REG_WIN_ORIGIN_Y  = 3'd5,
		REG_TABLE_BASE    = 3'd6,
		REG_LEVEL_RULE    = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] page_level;
		logic [COORD_W-1:0] page_col;
		logic [COORD_W-1:0] page_row;
	} in_beat_t;

	typedef struct packed {
		logic               found;
		logic [LOCAL_W-1:0] local_col;
		logic [LOCAL_W-1:0] local_row;
		logic [BASE_W-1:0]  entry_index;
	} out_beat_t;

	// register contents plus the derived consistency flag
	typedef struct packed {
		logic [DIM_W-1:0]  map_width_pages;
		logic [DIM_W-1:0]  map_height_pages;
		logic [DIM_W-1:0]  window_width_pages;
		logic [DIM_W-1:0]  window_height_pages;
		logic [DIM_W-1:0]  window_origin_x;
		logic [DIM_W-1:0]  window_origin_y;
		logic [BASE_W-1:0] table_base_entry;
		logic [RULE_W-1:0] level_rule;
		logic              consistent;
	} cfg_t;

endpackage

// ===== sv/shadow_page_table_index_router_unit.sv =====
// ----------------------------------------------------------------------------
// shadow_page_table_index_router_unit
// Checks shadow page requests against one projection window and computes
// the page table index.
// ----------------------------------------------------------------------------
// Usage:
//   Request beats (level, column, row) enter on in_valid/in_ready; one result
//   beat (found, local column/row, entry index) leaves on out_valid/out_ready
//   for every request, in order. Fields of a miss are all zero.
//   Registers are written on cfg_valid/cfg_ready (always ready) with an index
//   and data; write them only while no request is in flight.
//   Throughput is one beat per cycle while the receiver keeps out_ready high,
//   set by the three-stage pipeline: stage 1 does the window and level
//   checks and the map area and row products, stage 2 the level product and
//   row offset, stage 3 the final index add into the output register.
//   When the receiver stalls, each stage holds only while the stage after it
//   is full, so bubbles close up; in_ready falls once all three stages hold
//   beats and out_ready is low. Nothing is dropped or repeated.
//   Reset clears the pipeline valid bits and every configuration register to
//   zero, which leaves the router disabled (every request misses).
// ----------------------------------------------------------------------------
module shadow_page_table_index_router_unit #(
	parameter int MAX_LEVELS = sptir_pkg::DEF_MAX_LEVELS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  sptir_pkg::in_beat_t              in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output sptir_pkg::out_beat_t             out_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sptir_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sptir_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sptir_pkg::*;

	localparam int CMP_W = ($clog2(2 * MAX_LEVELS + 2) > LEVEL_W) ?
		$clog2(2 * MAX_LEVELS + 2) : LEVEL_W;
	localparam logic [CMP_W-1:0] LVL_COUNT = CMP_W'(MAX_LEVELS);
	localparam logic [CMP_W-1:0] DIR_BASE  = CMP_W'(MAX_LEVELS + 1);
	localparam int AREA_W = 2 * DIM_W;
	localparam int ROWP_W = COORD_W + DIM_W;
	localparam int LVLP_W = LEVEL_W + AREA_W;
	localparam int RC_W   = ROWP_W + 1;

	cfg_t cfg;

	sptir_cfg #(
		.MAX_LEVELS(MAX_LEVELS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// stage enables: a stage moves when it is empty or the next one moves
	logic en_s1, en_s2, en_s3;
	logic v_s1, v_s2, v_s3;

	assign en_s3    = !v_s3 || out_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	// stage 1 checks
	logic [CMP_W-1:0]   rule_ext, lvl_ext;
	logic [COORD_W-1:0] org_x_ext, org_y_ext, lc_full, lr_full;
	logic               level_ok, win_ok;

	always_comb begin
		rule_ext  = CMP_W'(cfg.level_rule);
		lvl_ext   = CMP_W'(in_data.page_level);
		org_x_ext = COORD_W'(cfg.window_origin_x);
		org_y_ext = COORD_W'(cfg.window_origin_y);
		lc_full   = in_data.page_col - org_x_ext;
		lr_full   = in_data.page_row - org_y_ext;
		if (rule_ext > LVL_COUNT) begin
			level_ok = (lvl_ext == (rule_ext - DIR_BASE));
		end else begin
			level_ok = (lvl_ext < rule_ext);
		end
		win_ok = (in_data.page_col >= org_x_ext) && (in_data.page_row >= org_y_ext) &&
			(lc_full < COORD_W'(cfg.window_width_pages)) &&
			(lr_full < COORD_W'(cfg.window_height_pages));
	end

	// pipeline registers
	logic                found_s1, found_s2;
	logic [LOCAL_W-1:0]  lc_s1, lr_s1, lc_s2, lr_s2;
	logic [LEVEL_W-1:0]  level_s1;
	logic [COORD_W-1:0]  col_s1;
	logic [AREA_W-1:0]   area_s1;
	logic [ROWP_W-1:0]   rowp_s1;
	logic [LVLP_W-1:0]   lvlp_s2;
	logic [RC_W-1:0]     rc_s2;
	out_beat_t           res_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	// stage 1: checks, local coordinates, area and row products
	always_ff @(posedge clk) begin
		if (en_s1) begin
			found_s1 <= cfg.consistent && level_ok && win_ok;
			lc_s1    <= lc_full[LOCAL_W-1:0];
			lr_s1    <= lr_full[LOCAL_W-1:0];
			level_s1 <= in_data.page_level;
			col_s1   <= in_data.page_col;
			area_s1  <= AREA_W'(cfg.map_width_pages) * AREA_W'(cfg.map_height_pages);
			rowp_s1  <= ROWP_W'(in_data.page_row) * ROWP_W'(cfg.map_width_pages);
		end
	end

	// stage 2: level product and row offset
	always_ff @(posedge clk) begin
		if (en_s2) begin
			found_s2 <= found_s1;
			lc_s2    <= lc_s1;
			lr_s2    <= lr_s1;
			lvlp_s2  <= LVLP_W'(level_s1) * LVLP_W'(area_s1);
			rc_s2    <= RC_W'(rowp_s1) + RC_W'(col_s1);
		end
	end

	// stage 3: final index, zeroed on a miss
	always_ff @(posedge clk) begin
		if (en_s3) begin
			res_s3.found <= found_s2;
			if (found_s2) begin
				res_s3.local_col   <= lc_s2;
				res_s3.local_row   <= lr_s2;
				res_s3.entry_index <= cfg.table_base_entry + BASE_W'(lvlp_s2) +
					BASE_W'(rc_s2);
			end else begin
				res_s3.local_col   <= '0;
				res_s3.local_row   <= '0;
				res_s3.entry_index <= '0;
			end
		end
	end

	assign out_valid = v_s3;
	assign out_data  = res_s3;

	// a miss carries all-zero fields
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.found) |->
		(out_data.local_col == '0 && out_data.local_row == '0 &&
		 out_data.entry_index == '0))
		else $error("miss result with nonzero fields");

	// input backpressure only when every stage is full and output is stalled
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && v_s2 && v_s3 && !out_ready))
		else $error("input stalled while the pipeline has room");

	// a hit needs an enabled rule and a local column inside the window
	a_hit_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.found) |->
		(cfg.level_rule != '0 &&
		 DIM_W'(out_data.local_col) < cfg.window_width_pages))
		else $error("hit result inconsistent with configuration");

endmodule

// ===== sv/sptir_cfg.sv =====
// ----------------------------------------------------------------------------
// sptir_cfg
// Configuration register file; also checks that the window fits the map.
// ----------------------------------------------------------------------------
module sptir_cfg #(
	parameter int MAX_LEVELS = sptir_pkg::DEF_MAX_LEVELS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sptir_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sptir_pkg::CFG_DATA_W-1:0] cfg_data,
	output sptir_pkg::cfg_t                  cfg
);
	import sptir_pkg::*;

	// wide enough to hold twice the level count
	localparam int CMP_W = ($clog2(2 * MAX_LEVELS + 2) > RULE_W) ?
		$clog2(2 * MAX_LEVELS + 2) : RULE_W;
	localparam logic [CMP_W-1:0] RULE_MAX = CMP_W'(2 * MAX_LEVELS);

	logic [DIM_W-1:0]  map_w_q, map_h_q, win_w_q, win_h_q, org_x_q, org_y_q;
	logic [BASE_W-1:0] base_q;
	logic [RULE_W-1:0] rule_q;
	logic [DIM_W-1:0]  room_x, room_y;
	logic              sizes_ok, rule_ok, fit_ok;

	assign cfg_ready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_w_q <= '0;
			map_h_q <= '0;
			win_w_q <= '0;
			win_h_q <= '0;
			org_x_q <= '0;
			org_y_q <= '0;
			base_q  <= '0;
			rule_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_MAP_WIDTH:    map_w_q <= cfg_data[DIM_W-1:0];
				REG_MAP_HEIGHT:   map_h_q <= cfg_data[DIM_W-1:0];
				REG_WIN_WIDTH:    win_w_q <= cfg_data[DIM_W-1:0];
				REG_WIN_HEIGHT:   win_h_q <= cfg_data[DIM_W-1:0];
				REG_WIN_ORIGIN_X: org_x_q <= cfg_data[DIM_W-1:0];
				REG_WIN_ORIGIN_Y: org_y_q <= cfg_data[DIM_W-1:0];
				REG_TABLE_BASE:   base_q  <= cfg_data[BASE_W-1:0];
				REG_LEVEL_RULE:   rule_q  <= cfg_data[RULE_W-1:0];
				default: ;
			endcase
		end
	end

	// consistency: nonzero sizes, valid rule, window inside the map
	always_comb begin
		room_x   = map_w_q - org_x_q;
		room_y   = map_h_q - org_y_q;
		sizes_ok = (map_w_q != '0) && (map_h_q != '0) &&
			(win_w_q != '0) && (win_h_q != '0);
		rule_ok  = (rule_q != '0) && (CMP_W'(rule_q) <= RULE_MAX);
		fit_ok   = (org_x_q <= map_w_q) && (org_y_q <= map_h_q) &&
			(win_w_q <= room_x) && (win_h_q <= room_y);
	end

	always_comb begin
		cfg.map_width_pages     = map_w_q;
		cfg.map_height_pages    = map_h_q;
		cfg.window_width_pages  = win_w_q;
		cfg.window_height_pages = win_h_q;
		cfg.window_origin_x     = org_x_q;
		cfg.window_origin_y     = org_y_q;
		cfg.table_base_entry    = base_q;
		cfg.level_rule          = rule_q;
		cfg.consistent          = sizes_ok && rule_ok && fit_ok;
	end

endmodule
